>>> design/irm_pkg.sv
//------------------------------------------------------------------------------
// irm_pkg: shared types and codes for the interval range map
// Transaction structs, status codes and controller/datapath command types.
//------------------------------------------------------------------------------
`default_nettype none
package irm_pkg;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] range_begin;
    logic [31:0] range_end;
    logic [31:0] new_value;
    logic [31:0] query_key;
  } irm_in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
  } irm_out_t;

  typedef struct packed {
    logic capture;
    logic evaluate;
    logic commit;
    logic init;
  } irm_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic empty;
    logic full;
  } irm_stat_t;

endpackage
`default_nettype wire

>>> design/irm_ctrl.sv
//------------------------------------------------------------------------------
// irm_ctrl: sequencer for the interval range map
// Steps each transaction through capture, evaluate and commit/respond.
//------------------------------------------------------------------------------
`default_nettype none
module irm_ctrl
  import irm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      cfg_we,
  input  wire irm_stat_t stat,
  output irm_cmd_t       cmd,
  output logic           busy,
  output logic           done,
  output status_t        done_status
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_COMMIT = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.init = cfg_we;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.evaluate = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = !stat.is_lookup && !stat.empty && !stat.full;
        state_next = S_RESP;
      end
      S_RESP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_COMMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_COMMIT) begin
      done_status <= stat.is_lookup ? ST_DONE : stat.empty ? ST_EMPTY :
                     stat.full ? ST_FULL : ST_DONE;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> done)
    else $error("commit without response");
  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("back-to-back responses");

endmodule
`default_nettype wire

>>> design/irm_dp.sv
//------------------------------------------------------------------------------
// irm_dp: breakpoint table datapath
// Holds the table in registers, compares all entries in parallel and
// rebuilds the canonical table by placing the range entries and shifting
// the entries above the range.
//------------------------------------------------------------------------------
`default_nettype none
module irm_dp
  import irm_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire irm_cmd_t              cmd,
  input  wire logic [VALUE_BITS-1:0] cfg_value,
  input  wire irm_in_t               in_item,
  output irm_stat_t                  stat,
  output logic [31:0]                read_value
);

  localparam int ECNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = ECNT_W + 1;

  logic [KEY_BITS-1:0]   keys [ENTRIES];
  logic [VALUE_BITS-1:0] vals [ENTRIES];
  logic [ECNT_W-1:0]     count;

  logic                  op;
  logic [KEY_BITS-1:0]   kb, ke, kq;
  logic [VALUE_BITS-1:0] nv;

  logic [ENTRIES-1:0]    in_tab;
  logic [ENTRIES-1:0]    le_q;
  logic [ENTRIES-1:0]    le_e;
  logic [ENTRIES-1:0]    lt_b;
  logic [ENTRIES-1:0]    lo_edge;
  logic [ENTRIES-1:0]    le_edge;

  logic [VALUE_BITS-1:0] q_val, e_val, b_prev;
  logic [ECNT_W-1:0]     n_lo, n_le;
  logic                  b_keep, e_keep;
  logic [CNT_W-1:0]      tail_at;

  logic [KEY_BITS-1:0]   n_key [ENTRIES];
  logic [VALUE_BITS-1:0] n_val [ENTRIES];
  logic [CNT_W-1:0]      n_cnt;
  logic [CNT_W-1:0]      cnt_r;
  logic                  full_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= in_item.op;
      kb <= KEY_BITS'(in_item.range_begin);
      ke <= KEY_BITS'(in_item.range_end);
      kq <= KEY_BITS'(in_item.query_key);
      nv <= VALUE_BITS'(in_item.new_value);
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      in_tab[i] = (ECNT_W'(i) < count);
      le_q[i] = in_tab[i] && (keys[i] <= kq);
      le_e[i] = in_tab[i] && (keys[i] <= ke);
      lt_b[i] = in_tab[i] && (keys[i] < kb);
    end
    q_val = vals[0];
    for (int i = 1; i < ENTRIES; i++) begin
      if (le_q[i]) q_val = vals[i];
    end
  end

  assign lo_edge = lt_b & ~(lt_b >> 1);
  assign le_edge = le_e & ~(le_e >> 1);

  always_comb begin
    n_lo = '0;
    n_le = '0;
    b_prev = '0;
    e_val = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (lo_edge[i]) begin
        n_lo = n_lo | ECNT_W'(i + 1);
        b_prev = b_prev | vals[i];
      end
      if (le_edge[i]) begin
        n_le = n_le | ECNT_W'(i + 1);
        e_val = e_val | vals[i];
      end
    end
    b_keep = (n_lo == '0) || (b_prev != nv);
    e_keep = (e_val != nv);
    tail_at = CNT_W'(n_lo) + CNT_W'(b_keep) + CNT_W'(e_keep);
    n_cnt = tail_at + CNT_W'(count) - CNT_W'(n_le);
  end

  // Keep entries below begin, place begin and end, shift entries above end.
  always_comb begin
    logic [CNT_W-1:0] src;
    for (int j = 0; j < ENTRIES; j++) begin
      src = CNT_W'(j) + CNT_W'(n_le) - tail_at;
      n_key[j] = keys[j];
      n_val[j] = vals[j];
      if (b_keep && CNT_W'(j) == CNT_W'(n_lo)) begin
        n_key[j] = kb;
        n_val[j] = nv;
      end else if (e_keep && CNT_W'(j) == tail_at - CNT_W'(1)) begin
        n_key[j] = ke;
        n_val[j] = e_val;
      end else if (CNT_W'(j) >= tail_at && src < CNT_W'(ENTRIES)) begin
        n_key[j] = keys[src[IDX_W-1:0]];
        n_val[j] = vals[src[IDX_W-1:0]];
      end
    end
  end

  logic [KEY_BITS-1:0]   s_key [ENTRIES];
  logic [VALUE_BITS-1:0] s_val [ENTRIES];

  always_ff @(posedge clk) begin
    if (cmd.evaluate) begin
      for (int i = 0; i < ENTRIES; i++) begin
        s_key[i] <= n_key[i];
        s_val[i] <= n_val[i];
      end
      cnt_r  <= n_cnt;
      full_r <= (n_cnt > CNT_W'(ENTRIES));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= ECNT_W'(1);
      keys[0] <= '0;
      vals[0] <= '0;
    end else if (cmd.init) begin
      count <= ECNT_W'(1);
      keys[0] <= '0;
      vals[0] <= cfg_value;
    end else if (cmd.commit) begin
      count <= cnt_r[ECNT_W-1:0];
      for (int i = 0; i < ENTRIES; i++) begin
        keys[i] <= s_key[i];
        vals[i] <= s_val[i];
      end
    end
  end

  assign stat.is_lookup = (op == OP_LOOKUP);
  assign stat.empty = !(kb < ke);
  assign stat.full = full_r;

  always_ff @(posedge clk) begin
    if (cmd.evaluate) begin
      read_value <= (op == OP_LOOKUP) ? 32'(q_val) : '0;
    end
  end

  a_count_ok: assert property (@(posedge clk) disable iff (rst)
    (count >= ECNT_W'(1)) && (count <= ECNT_W'(ENTRIES)))
    else $error("entry count out of range");
  a_first_key: assert property (@(posedge clk) disable iff (rst)
    keys[0] == '0)
    else $error("first breakpoint not zero");
  a_no_commit_full: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !full_r)
    else $error("commit of overfull table");

endmodule
`default_nettype wire

>>> design/interval_range_map.sv
//------------------------------------------------------------------------------
// interval_range_map: range-assign / point-lookup breakpoint table
//
// Usage: drive req and raise start while busy is low; the transaction is
// taken at that edge. op selects a range assign or a key lookup. Exactly
// one result appears on rsp with done high for one cycle, after parallel
// compare and table rebuild, commit and respond; busy stays high through
// that response, so one transaction runs at a time. The receiver cannot
// stall; rsp is valid only while done is high. cfg_we with cfg_data
// writes initial_value and resets the table to one entry holding that
// value; the user must raise cfg_we only while idle, which the block does
// not enforce. Reset (rst, synchronous) leaves a single entry with value
// zero and no transaction in flight.
//------------------------------------------------------------------------------
`default_nettype none
module interval_range_map
  import irm_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire irm_in_t     req,
  output logic             busy,
  output logic             done,
  output irm_out_t         rsp,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data
);

  irm_cmd_t    cmd;
  irm_stat_t   stat;
  status_t     st;
  logic [31:0] rv;

  irm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cfg_we(cfg_we), .stat(stat),
    .cmd(cmd), .busy(busy), .done(done), .done_status(st)
  );

  irm_dp #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .cfg_value(VALUE_BITS'(cfg_data)),
    .in_item(req), .stat(stat), .read_value(rv)
  );

  assign rsp.read_value = rv;
  assign rsp.status = st;

endmodule
`default_nettype wire

>>> bench/interval_range_map_tb.sv
//------------------------------------------------------------------------------
// interval_range_map_tb: self-checking bench for the interval range map
// Drives assign and lookup transactions through the start/busy handshake and
// compares every done-strobed response against a breakpoint-table predictor.
// A directed table covers the extremes, empty ranges and table overflow, then
// random phases run with varying sender idling and initial_value settings.
//------------------------------------------------------------------------------
`default_nettype none
module interval_range_map_tb
  import irm_pkg::*;
();

  localparam int NUM_ENTRIES = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  irm_in_t     req = '0;
  logic        busy;
  logic        done;
  irm_out_t    rsp;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  interval_range_map u_top (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy), .done(done),
    .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] bk_key [NUM_ENTRIES];
  logic [31:0] bk_val [NUM_ENTRIES];
  int          bk_count;
  irm_out_t    rsp_queue[$];
  int          errors = 0;
  int          cycles = 0;
  int          idle_pct = 0;

  typedef struct {
    irm_in_t  item;
    logic     known;
    irm_out_t want;
  } dir_row_t;

  task automatic report(input string what, input irm_out_t got, input irm_out_t want);
    $display("mismatch %s: got value %h status %0d, want value %h status %0d",
             what, got.read_value, got.status, want.read_value, want.status);
    errors++;
  endtask

  function automatic void table_reinit(input logic [31:0] v);
    bk_key[0] = '0;
    bk_val[0] = v;
    bk_count = 1;
  endfunction

  function automatic logic [31:0] value_at(input logic [31:0] key);
    logic [31:0] v;
    v = bk_val[0];
    for (int i = 1; i < bk_count; i++)
      if (bk_key[i] <= key) v = bk_val[i];
    return v;
  endfunction

  function automatic irm_out_t map_step(input irm_in_t it);
    irm_out_t    r;
    logic [31:0] nk [NUM_ENTRIES + 2];
    logic [31:0] nv [NUM_ENTRIES + 2];
    logic [31:0] kk [NUM_ENTRIES + 2];
    logic [31:0] vv [NUM_ENTRIES + 2];
    int          n;
    int          m;
    r = '0;
    if (it.op == OP_LOOKUP) begin
      r.read_value = value_at(it.query_key);
      r.status = ST_DONE;
      return r;
    end
    if (!(it.range_begin < it.range_end)) begin
      r.status = ST_EMPTY;
      return r;
    end
    m = 0;
    for (int i = 0; i < bk_count; i++)
      if (bk_key[i] < it.range_begin) begin
        kk[m] = bk_key[i]; vv[m] = bk_val[i]; m++;
      end
    kk[m] = it.range_begin; vv[m] = it.new_value; m++;
    kk[m] = it.range_end; vv[m] = value_at(it.range_end); m++;
    for (int i = 0; i < bk_count; i++)
      if (bk_key[i] > it.range_end) begin
        kk[m] = bk_key[i]; vv[m] = bk_val[i]; m++;
      end
    n = 0;
    for (int i = 0; i < m; i++)
      if (n == 0 || nv[n-1] != vv[i]) begin
        nk[n] = kk[i]; nv[n] = vv[i]; n++;
      end
    if (n > NUM_ENTRIES) begin
      r.status = ST_FULL;
      return r;
    end
    for (int i = 0; i < n; i++) begin
      bk_key[i] = nk[i];
      bk_val[i] = nv[i];
    end
    bk_count = n;
    r.status = ST_DONE;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    irm_out_t want;
    if (!rst && done) begin
      if (rsp_queue.size() == 0) begin
        report("unexpected", rsp, '0);
      end else begin
        want = rsp_queue.pop_front();
        if (rsp.read_value !== want.read_value) report("read_value", rsp, want);
        if (rsp.status !== want.status) report("status", rsp, want);
      end
    end
  end

  task automatic send(input irm_in_t it, input logic known, input irm_out_t want);
    irm_out_t p;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      req <= '0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = map_step(it);
    if (known && p !== want) report("directed row", p, want);
    rsp_queue.push_back(p);
  endtask

  task automatic settle_and_config(input logic [31:0] v);
    start <= 1'b0;
    req <= '0;
    while (rsp_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    table_reinit(v);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(63);
    endcase
  endfunction

  function automatic irm_in_t rand_item();
    irm_in_t it;
    it.op = $urandom_range(2) == 0 ? OP_LOOKUP : OP_ASSIGN;
    it.range_begin = pick_key();
    it.range_end = $urandom_range(5) == 0 ? pick_key() : it.range_begin + $urandom_range(12);
    it.new_value = $urandom_range(3) == 0 ? $urandom : $urandom_range(5);
    it.query_key = pick_key();
    return it;
  endfunction

  function automatic irm_in_t mk(input logic op, input logic [31:0] b, input logic [31:0] e,
                                 input logic [31:0] v, input logic [31:0] q);
    irm_in_t it;
    it.op = op; it.range_begin = b; it.range_end = e; it.new_value = v; it.query_key = q;
    return it;
  endfunction

  function automatic irm_out_t res(input logic [31:0] v, input status_t s);
    irm_out_t r;
    r.read_value = v;
    r.status = s;
    return r;
  endfunction

  initial begin
    dir_row_t rows[$];
    irm_in_t  it;
    table_reinit('0);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back('{mk(OP_LOOKUP, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0), 1, res(0, ST_DONE)});
    rows.push_back('{mk(OP_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF), 1, res(0, ST_DONE)});
    rows.push_back('{mk(OP_ASSIGN, 5, 5, 7, 32'hFFFF_FFFF), 1, res(0, ST_EMPTY)});
    rows.push_back('{mk(OP_ASSIGN, 32'hFFFF_FFFF, 0, 7, 0), 1, res(0, ST_EMPTY)});
    rows.push_back('{mk(OP_ASSIGN, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0), 1, res(0, ST_DONE)});
    rows.push_back('{mk(OP_LOOKUP, 0, 0, 0, 32'hFFFF_FFFE), 1, res(32'hFFFF_FFFF, ST_DONE)});
    rows.push_back('{mk(OP_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF), 1, res(0, ST_DONE)});
    rows.push_back('{mk(OP_ASSIGN, 10, 20, 32'hFFFF_FFFF, 0), 0, '0});
    rows.push_back('{mk(OP_ASSIGN, 15, 30, 0, 0), 0, '0});
    for (int i = 0; i < 10; i++)
      rows.push_back('{mk(OP_ASSIGN, 100 + 4*i, 102 + 4*i, i + 1, 0), 0, '0});
    rows.push_back('{mk(OP_ASSIGN, 200, 202, 9, 0), 1, res(0, ST_FULL)});
    rows.push_back('{mk(OP_LOOKUP, 0, 0, 0, 12), 0, '0});
    rows.push_back('{mk(OP_LOOKUP, 0, 0, 0, 105), 0, '0});
    rows.push_back('{mk(OP_ASSIGN, 0, 32'hFFFF_FFFF, 3, 0), 0, '0});
    foreach (rows[i]) send(rows[i].item, rows[i].known, rows[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  settle_and_config(32'hFFFF_FFFF); end
        1: begin idle_pct = 88; settle_and_config(32'h0); end
        2: begin idle_pct = 34; settle_and_config($urandom); end
        default: begin idle_pct = 0; settle_and_config(32'h5); end
      endcase
      for (int k = 0; k < 150; k++) begin
        it = rand_item();
        send(it, 1'b0, '0);
      end
    end

    start <= 1'b0;
    req <= '0;
    while (rsp_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
design/irm_pkg.sv
design/irm_ctrl.sv
design/irm_dp.sv
design/interval_range_map.sv
bench/interval_range_map_tb.sv
